// ===== rtl/core/cab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cab_pkg;

	localparam int unsigned ARENA_BYTES_DEF = 32 * 1024;
	localparam int unsigned MAX_ARENAS_DEF = 12;

	localparam int unsigned SIZE_W = 16;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned DEPTH_W = 4;
	// holds cursor plus size for any arena size in range
	localparam int unsigned SUM_W = 18;
	// compare width for a handle arena against the in-use count
	localparam int unsigned HCMP_W = IDX_W + 1;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(10);

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_REALLOC = 2'd1,
		CMD_FREE    = 2'd2,
		CMD_RESET   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EXEC,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic walk;
		logic exec;
		logic publish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cab_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cab_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic [1:0]        req_cmd,
	output logic                   req_stall,
	input  wire cab_pkg::dp_status_t status,
	output cab_pkg::ctrl_cmd_t     ctl
);
	import cab_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d = (cmd_t'(req_cmd) == CMD_ALLOC) ? ST_WALK : ST_EXEC;
				end
			end
			ST_WALK: begin
				ctl.walk = 1'b1;
				if (status.walk_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				// wait for the output register to drain
				if (status.out_free) begin
					ctl.publish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/cab_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cab_dp #(
	parameter int unsigned ARENA_BYTES = cab_pkg::ARENA_BYTES_DEF,
	parameter int unsigned MAX_ARENAS = cab_pkg::MAX_ARENAS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cab_pkg::DEPTH_W-1:0]   cfg_data,
	input  wire logic [1:0]                    req_cmd,
	input  wire logic [cab_pkg::SIZE_W-1:0]    req_size,
	input  wire logic [cab_pkg::IDX_W-1:0]     req_handle_arena,
	input  wire logic [cab_pkg::SIZE_W-1:0]    req_handle_offset,
	input  wire cab_pkg::ctrl_cmd_t            ctl,
	output cab_pkg::dp_status_t                status,
	input  wire logic                          rsp_stall,
	output logic                               rsp_valid,
	output logic                               ok,
	output logic [cab_pkg::IDX_W-1:0]          out_arena,
	output logic [cab_pkg::SIZE_W-1:0]         out_offset
);
	import cab_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ARENAS);
	localparam int unsigned NW = $clog2(MAX_ARENAS + 1);
	localparam int unsigned CUR_W = $clog2(ARENA_BYTES + 1);

	logic [CUR_W-1:0]   cursors_q [MAX_ARENAS];
	logic [CUR_W-1:0]   last_off_q [MAX_ARENAS];
	logic [MAX_ARENAS-1:0] last_valid_q;
	logic [NW-1:0]      in_use_q;
	logic [DEPTH_W-1:0] cfg_depth_q;

	cmd_t               cmd_q;
	logic [SIZE_W-1:0]  size_q;
	logic [IDX_W-1:0]   ha_q;
	logic [SIZE_W-1:0]  ho_q;
	logic [AW-1:0]      arena_q;
	logic [DEPTH_W-1:0] depth_q;

	logic               res_ok_q;
	logic [IDX_W-1:0]   res_arena_q;
	logic [SIZE_W-1:0]  res_off_q;
	logic               rsp_valid_q;

	logic [CUR_W-1:0]   cur;
	logic [SUM_W-1:0]   alloc_sum;
	logic               fit;
	logic               next_in_use;
	logic               walk_fail;
	logic [AW-1:0]      ha_idx;
	logic               match;
	logic [SUM_W-1:0]   ho_sum;
	logic               re_fit;
	logic               exec_ok;
	logic [IDX_W-1:0]   exec_arena;
	logic [SIZE_W-1:0]  exec_off;

	assign cur = cursors_q[arena_q];
	assign alloc_sum = SUM_W'(cur) + SUM_W'(size_q);
	assign fit = alloc_sum <= SUM_W'(ARENA_BYTES);
	assign next_in_use = (NW'(arena_q) + NW'(1)) < in_use_q;
	// depth limit first, then out of arenas to bring in
	assign walk_fail = !fit && ((depth_q > cfg_depth_q) ||
		(!next_in_use && (in_use_q >= NW'(MAX_ARENAS))));

	assign ha_idx = ha_q[AW-1:0];
	assign match = (HCMP_W'(ha_q) < HCMP_W'(in_use_q)) && last_valid_q[ha_idx] &&
		(SUM_W'(last_off_q[ha_idx]) == SUM_W'(ho_q));
	assign ho_sum = SUM_W'(ho_q) + SUM_W'(size_q);
	assign re_fit = ho_sum < SUM_W'(ARENA_BYTES);

	always_comb begin
		exec_ok = 1'b0;
		exec_arena = '0;
		exec_off = '0;
		case (cmd_q)
			CMD_REALLOC: begin
				if (match && re_fit) begin
					exec_ok = 1'b1;
					exec_arena = ha_q;
					exec_off = ho_q;
				end
			end
			CMD_FREE: exec_ok = match;
			CMD_RESET: exec_ok = 1'b1;
			default: exec_ok = 1'b0;
		endcase
	end

	assign status.walk_done = fit || walk_fail;
	assign status.out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			cfg_depth_q <= cfg_data;
		end
	end

	// arena state and walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ARENAS; i++) begin
				cursors_q[i] <= '0;
			end
			last_valid_q <= '0;
			in_use_q <= NW'(1);
			arena_q <= '0;
			depth_q <= '0;
			cmd_q <= CMD_ALLOC;
		end else begin
			if (ctl.load) begin
				cmd_q <= cmd_t'(req_cmd);
				arena_q <= '0;
				depth_q <= '0;
			end
			if (ctl.walk) begin
				if (fit) begin
					cursors_q[arena_q] <= CUR_W'(alloc_sum);
					last_valid_q[arena_q] <= 1'b1;
				end else if (!walk_fail) begin
					depth_q <= depth_q + DEPTH_W'(1);
					if (next_in_use) begin
						arena_q <= arena_q + AW'(1);
					end else begin
						// bring the next arena into use
						arena_q <= AW'(in_use_q);
						in_use_q <= in_use_q + NW'(1);
						cursors_q[AW'(in_use_q)] <= '0;
						last_valid_q[AW'(in_use_q)] <= 1'b0;
					end
				end
			end
			if (ctl.exec) begin
				case (cmd_q)
					CMD_REALLOC: begin
						if (match && re_fit) begin
							cursors_q[ha_idx] <= CUR_W'(ho_sum);
						end
					end
					CMD_FREE: begin
						if (match) begin
							cursors_q[ha_idx] <= CUR_W'(ho_q);
						end
					end
					CMD_RESET: begin
						for (int i = 0; i < MAX_ARENAS; i++) begin
							cursors_q[i] <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.walk && fit) begin
			last_off_q[arena_q] <= cur;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			size_q <= req_size;
			ha_q <= req_handle_arena;
			ho_q <= req_handle_offset;
		end
	end

	// transaction result, held until the output register is free
	always_ff @(posedge clk) begin
		if (ctl.walk && status.walk_done) begin
			res_ok_q <= fit;
			res_arena_q <= fit ? IDX_W'(arena_q) : '0;
			res_off_q <= fit ? SIZE_W'(cur) : '0;
		end else if (ctl.exec) begin
			res_ok_q <= exec_ok;
			res_arena_q <= exec_arena;
			res_off_q <= exec_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.publish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.publish) begin
			ok <= res_ok_q;
			out_arena <= res_arena_q;
			out_offset <= res_off_q;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/chained_bump_arena_allocator.sv =====
// alloc walks the arenas from arena 0 until one fits or the walk fails, then waits in the
//   result state for the output register; realloc, free and reset skip the walk and execute
//   directly. One transaction at a time: req_stall is high from accept until the result is
//   published, and the arena walk checks one cursor per cycle
// reset: arst_n clears all cursors and recorded allocations, one arena in use, depth limit 10
`timescale 1ns / 1ps
`default_nettype none

module chained_bump_arena_allocator #(
	parameter int unsigned ARENA_BYTES = cab_pkg::ARENA_BYTES_DEF,
	parameter int unsigned MAX_ARENAS = cab_pkg::MAX_ARENAS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [cab_pkg::DEPTH_W-1:0] cfg_data,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire logic [1:0]                  cmd,
	input  wire logic [cab_pkg::SIZE_W-1:0]  size,
	input  wire logic [cab_pkg::IDX_W-1:0]   handle_arena,
	input  wire logic [cab_pkg::SIZE_W-1:0]  handle_offset,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output logic                             ok,
	output logic [cab_pkg::IDX_W-1:0]        out_arena,
	output logic [cab_pkg::SIZE_W-1:0]       out_offset
);
	import cab_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t status;

	cab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (cmd),
		.req_stall (req_stall),
		.status    (status),
		.ctl       (ctl)
	);

	cab_dp #(
		.ARENA_BYTES (ARENA_BYTES),
		.MAX_ARENAS  (MAX_ARENAS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data),
		.req_cmd           (cmd),
		.req_size          (size),
		.req_handle_arena  (handle_arena),
		.req_handle_offset (handle_offset),
		.ctl               (ctl),
		.status            (status),
		.rsp_stall         (rsp_stall),
		.rsp_valid         (rsp_valid),
		.ok                (ok),
		.out_arena         (out_arena),
		.out_offset        (out_offset)
	);

endmodule

`default_nettype wire

// ===== rtl/core/cab_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cab_sva #(
	parameter int unsigned MAX_ARENAS = cab_pkg::MAX_ARENAS_DEF
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_stall,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_stall,
	input wire logic                        ok,
	input wire logic [cab_pkg::IDX_W-1:0]   out_arena,
	input wire logic [cab_pkg::SIZE_W-1:0]  out_offset
);
	import cab_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(ok) && $stable(out_arena) &&
			$stable(out_offset))
		else $error("stalled result changed");

	// one transaction at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("accepted a second transaction while busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> out_arena == '0 && out_offset == '0)
		else $error("failed result carries a handle");

	a_arena_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ok |-> HCMP_W'(out_arena) < HCMP_W'(MAX_ARENAS))
		else $error("result arena out of range");

endmodule

bind chained_bump_arena_allocator cab_sva #(
	.MAX_ARENAS (MAX_ARENAS)
) u_cab_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.ok         (ok),
	.out_arena  (out_arena),
	.out_offset (out_offset)
);

`default_nettype wire
